// File: sv/assert_macros.svh
// Assertion helpers. They expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/vfc_pkg.sv
`timescale 1ns / 1ps

package vfc_pkg;

  typedef logic [1:0] code_t;
  typedef logic [1:0] kind_t;
  typedef logic [6:0] dim_t;

  // Voxel codes held in the store.
  localparam code_t CODE_FREE     = 2'd0;
  localparam code_t CODE_OCCUPIED = 2'd1;
  localparam code_t CODE_UNKNOWN  = 2'd2;

  // Result kinds.
  localparam kind_t KIND_NEITHER  = 2'd0;
  localparam kind_t KIND_FRONTIER = 2'd1;
  localparam kind_t KIND_BOUNDARY = 2'd2;

  // Item functions.
  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

  localparam dim_t DIM_RESET = 7'd64;

endpackage

// File: sv/vfc_ram.sv
`timescale 1ns / 1ps

// Single write port, two read ports, registered read data with a read enable.
module vfc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: sv/voxel_frontier_classifier.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  func, x/y/z index, cell code
// out_      output     out_valid/out_stall kind, voxel index, in-range flag
// cfg_      input      cfg_wr_en          register index, write data
//
// An in-range write transfer is written to the store at the edge of the transfer.
// A classify transfer walks R1, R2, R3 and FIN: seven store reads (the voxel and its six
// neighbours) share the two read ports of the occupancy memory, two reads a cycle.
// Reset (rst_n, synchronous, active low) clears the control state and sets each grid
// dimension to 64. The store itself is not cleared: entries hold garbage until written.
// A stalled result sits in the output register; the next item is taken while it waits,
// and a finished classify holds its read data until the output register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module voxel_frontier_classifier
  import vfc_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [5:0]           in_x_index,
  input  logic [5:0]           in_y_index,
  input  logic [5:0]           in_z_index,
  input  logic [1:0]           in_cell_code,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [17:0]          out_voxel_index,
  output logic                 out_in_range,
  // Configuration port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]           cfg_wdata
);

  // The store is addressed by the concatenated coordinates, each trimmed to the bits
  // that MAX_DIM needs. Only writes below the effective dimensions reach it.
  localparam int CW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW      = 3 * CW;
  localparam int DEPTH   = 1 << AW;
  localparam int DIM_CAP = (MAX_DIM > 127) ? 127 : MAX_DIM;

  // Sequencer states. A classify walks R1 to FIN; R1, R2 and R3 each issue one pair of
  // reads and take in the data of the pair issued in the cycle before.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_R1   = 3'd1;
  localparam logic [2:0] S_R2   = 3'd2;
  localparam logic [2:0] S_R3   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  dim_t        grid_length_r, grid_width_r, grid_height_r;
  dim_t        eff_l, eff_w, eff_h;

  logic [5:0]  x_r, y_r, z_r;
  logic        inside_r;
  logic        free_r, free_nxt;
  logic [13:0] wh_r;
  logic [12:0] yh_r;
  logic [17:0] lin_r;
  logic [19:0] x_times_wh;
  logic [20:0] lin_sum;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [17:0] out_voxel_index_r;
  logic        out_in_range_r;

  logic        out_free;
  logic        in_acc;
  logic        inside_c;
  logic        fin_go;
  kind_t       kind_c;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr_a, mem_raddr_b;
  code_t         mem_rdata_a, mem_rdata_b;
  logic          nbr_ok_a, nbr_ok_b;

  // A register value above MAX_DIM acts as MAX_DIM.
  function automatic dim_t eff_dim(input dim_t raw);
    dim_t cap;
    cap = 7'(DIM_CAP);
    return (raw > cap) ? cap : raw;
  endfunction

  assign eff_l = eff_dim(grid_length_r);
  assign eff_w = eff_dim(grid_width_r);
  assign eff_h = eff_dim(grid_height_r);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_length_r <= DIM_RESET;
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_LENGTH: grid_length_r <= cfg_wdata;
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  // The output register is free when it is empty or its result leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // FIN completes once its result can go into the output register.
  assign fin_go   = (state_r == S_FIN) && out_free;
  assign in_stall = !((state_r == S_IDLE) || fin_go);
  assign in_acc   = in_valid && !in_stall;

  assign inside_c = ({1'b0, in_x_index} < eff_l) &&
                    ({1'b0, in_y_index} < eff_w) &&
                    ({1'b0, in_z_index} < eff_h);

  // ---------------------------------------------------------------------------
  // Occupancy store
  // ---------------------------------------------------------------------------
  // A write lands at the edge of its transfer. Every read of a classify is issued by
  // the end of R3, and a new transfer is only taken in IDLE or FIN, so a write never
  // overlaps the reads of an item still in flight and no forwarding is needed.
  assign mem_we    = in_acc && (in_func == FUNC_WRITE) && inside_c;
  assign mem_waddr = {CW'(in_x_index), CW'(in_y_index), CW'(in_z_index)};

  // Read slots: x neighbours on the transfer edge (taken straight from the ports),
  // then y neighbours, z neighbours and finally the voxel itself.
  always_comb begin
    unique case (state_r)
      S_R1: begin
        mem_raddr_a = {CW'(x_r), CW'(y_r - 6'd1), CW'(z_r)};
        mem_raddr_b = {CW'(x_r), CW'({1'b0, y_r} + 7'd1), CW'(z_r)};
      end
      S_R2: begin
        mem_raddr_a = {CW'(x_r), CW'(y_r), CW'(z_r - 6'd1)};
        mem_raddr_b = {CW'(x_r), CW'(y_r), CW'({1'b0, z_r} + 7'd1)};
      end
      S_R3: begin
        mem_raddr_a = {CW'(x_r), CW'(y_r), CW'(z_r)};
        mem_raddr_b = {CW'(x_r), CW'(y_r), CW'(z_r)};
      end
      default: begin
        mem_raddr_a = {CW'(in_x_index - 6'd1), CW'(in_y_index), CW'(in_z_index)};
        mem_raddr_b = {CW'({1'b0, in_x_index} + 7'd1), CW'(in_y_index), CW'(in_z_index)};
      end
    endcase
  end

  // A FIN that waits on the output keeps its read data.
  assign mem_re = !((state_r == S_FIN) && !out_free);

  vfc_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (in_cell_code),
    .rd_en     (mem_re),
    .rd_addr_a (mem_raddr_a),
    .rd_addr_b (mem_raddr_b),
    .rd_data_a (mem_rdata_a),
    .rd_data_b (mem_rdata_b)
  );

  // ---------------------------------------------------------------------------
  // Neighbour checks
  // ---------------------------------------------------------------------------
  // Whether the neighbour whose data arrives this cycle lies inside the grid along the
  // axis it steps on. The other two axes are covered by the voxel's own in-range flag.
  always_comb begin
    unique case (state_r)
      S_R1: begin
        nbr_ok_a = (x_r != 6'd0);
        nbr_ok_b = (({1'b0, x_r} + 7'd1) < eff_l);
      end
      S_R2: begin
        nbr_ok_a = (y_r != 6'd0);
        nbr_ok_b = (({1'b0, y_r} + 7'd1) < eff_w);
      end
      S_R3: begin
        nbr_ok_a = (z_r != 6'd0);
        nbr_ok_b = (({1'b0, z_r} + 7'd1) < eff_h);
      end
      default: begin
        nbr_ok_a = 1'b0;
        nbr_ok_b = 1'b0;
      end
    endcase
  end

  always_comb begin
    free_nxt = (state_r == S_R1) ? 1'b0 : free_r;
    if ((state_r == S_R1) || (state_r == S_R2) || (state_r == S_R3)) begin
      free_nxt = free_nxt ||
                 (nbr_ok_a && (mem_rdata_a == CODE_FREE)) ||
                 (nbr_ok_b && (mem_rdata_b == CODE_FREE));
    end
  end

  // In FIN the voxel's own code sits on read port A.
  always_comb begin
    kind_c = KIND_NEITHER;
    if (inside_r && free_r) begin
      priority if (mem_rdata_a == CODE_UNKNOWN) begin
        kind_c = KIND_FRONTIER;
      end else if (mem_rdata_a == CODE_OCCUPIED) begin
        kind_c = KIND_BOUNDARY;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Linear index: one multiply stage in R1, the second in R2.
  // ---------------------------------------------------------------------------
  assign x_times_wh = 20'(x_r) * 20'(wh_r);
  assign lin_sum    = 21'(x_times_wh) + 21'(yh_r) + 21'(z_r);

  always_ff @(posedge clk) begin
    if (state_r == S_R1) begin
      wh_r <= 14'(eff_w) * 14'(eff_h);
      yh_r <= 13'(y_r) * 13'(eff_h);
    end
    if (state_r == S_R2) begin
      lin_r <= lin_sum[17:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Item registers and sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r      <= in_x_index;
      y_r      <= in_y_index;
      z_r      <= in_z_index;
      inside_r <= inside_c;
    end
    free_r <= free_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE, S_FIN: begin
        if (state_r == S_FIN && fin_go) begin
          state_nxt = S_IDLE;
        end
        if (in_acc && (in_func == FUNC_CLASSIFY)) begin
          state_nxt = S_R1;
        end
      end
      S_R1: state_nxt = S_R2;
      S_R2: state_nxt = S_R3;
      S_R3: state_nxt = S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_kind_r        <= kind_c;
      out_voxel_index_r <= lin_r;
      out_in_range_r    <= inside_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_voxel_index = out_voxel_index_r;
  assign out_in_range    = out_in_range_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The store is never written while a classify still has reads to issue.
  `ASSERT_IMPLIES(a_no_write_mid_read, clk, rst_n, mem_we, (state_r == S_IDLE) || (state_r == S_FIN))
  // An accepted classify enters R1 in the next cycle.
  `ASSERT_NEXT(a_classify_starts, clk, rst_n, in_acc && (in_func == FUNC_CLASSIFY), state_r == S_R1)
  // The last read slot always leads to the completion state.
  `ASSERT_NEXT(a_r3_to_fin, clk, rst_n, state_r == S_R3, state_r == S_FIN)
  // Only a voxel inside the grid can be a frontier or a boundary.
  `ASSERT_IMPLIES(a_kind_in_range, clk, rst_n, out_valid_r && (out_kind_r != KIND_NEITHER), out_in_range_r)

endmodule

// File: tb/sv/voxel_frontier_classifier_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the voxel frontier classifier.
// A planning process in the initial block queues voxel writes and classify requests. The
// driver presents them one transfer at a time, and the occupancy mirror is updated as each
// transfer is accepted. The monitor compares every result transfer with the oldest
// outstanding verdict.
module voxel_frontier_classifier_tb;
  import vfc_pkg::*;

  localparam int GRID_MAX = 64;
  localparam int STORE_SIZE = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int REBOX_PERIOD = 20;

  // The block stores the fourth code as given; it is never free and never classified.
  localparam code_t CODE_RESERVED = 2'd3;

  typedef struct {
    logic       func;
    logic [5:0] x;
    logic [5:0] y;
    logic [5:0] z;
    code_t      code;
    bit         hold_for_drain;
  } voxel_req_t;

  typedef struct {
    kind_t       kind;
    logic [17:0] index;
    logic        in_range;
  } voxel_verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = FUNC_WRITE;
  logic [5:0]  in_x_index = '0;
  logic [5:0]  in_y_index = '0;
  logic [5:0]  in_z_index = '0;
  logic [1:0]  in_cell_code = CODE_FREE;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [17:0] out_voxel_index;
  logic        out_in_range;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_LENGTH;
  logic [6:0]  cfg_wdata = DIM_RESET;

  voxel_frontier_classifier #(
    .MAX_DIM(GRID_MAX)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_x_index     (in_x_index),
    .in_y_index     (in_y_index),
    .in_z_index     (in_z_index),
    .in_cell_code   (in_cell_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_voxel_index(out_voxel_index),
    .out_in_range   (out_in_range),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Occupancy mirror, indexed exactly as the block's store, and the grid registers as last
  // written. The seeded map belongs to the planner: it records which entries will have
  // been written by the time a queued classify reaches the block, so that no classify ever
  // looks at a voxel that was never written.
  code_t occupancy_mirror [STORE_SIZE];
  bit    seeded [STORE_SIZE];
  dim_t  grid_len_q = DIM_RESET;
  dim_t  grid_wid_q = DIM_RESET;
  dim_t  grid_hgt_q = DIM_RESET;

  voxel_req_t     pending_reqs [$];
  voxel_verdict_t expected_verdicts [$];
  voxel_req_t     cur_req;
  voxel_verdict_t oldest;

  // The driver owns verdicts_owed and the monitor owns verdicts_seen. The latter is
  // updated with a nonblocking assignment so that the driver always reads a settled value.
  int verdicts_owed = 0;
  int verdicts_seen = 0;
  int planned_items = 0;
  int faults = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // A register value above the largest grid acts as the largest grid.
  function automatic int clamp_dim(dim_t raw);
    return (raw > GRID_MAX) ? GRID_MAX : int'(raw);
  endfunction

  function automatic int mirror_addr(int x, int y, int z);
    return (x * GRID_MAX + y) * GRID_MAX + z;
  endfunction

  function automatic bit within_grid(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < clamp_dim(grid_len_q) &&
           y < clamp_dim(grid_wid_q) && z < clamp_dim(grid_hgt_q);
  endfunction

  // Neighbours outside the configured grid never count as free.
  function automatic bit free_neighbour(int x, int y, int z);
    if (!within_grid(x, y, z)) return 1'b0;
    return occupancy_mirror[mirror_addr(x, y, z)] == CODE_FREE;
  endfunction

  function automatic voxel_verdict_t classify_voxel(int x, int y, int z);
    voxel_verdict_t v;
    int dw;
    int dh;
    bit any_free;
    code_t self_code;
    dw = clamp_dim(grid_wid_q);
    dh = clamp_dim(grid_hgt_q);
    v.kind = KIND_NEITHER;
    // The linear index uses the effective dimensions and is reported even out of range.
    v.index = 18'(x * dw * dh + y * dh + z);
    v.in_range = within_grid(x, y, z);
    if (v.in_range) begin
      self_code = occupancy_mirror[mirror_addr(x, y, z)];
      any_free = free_neighbour(x - 1, y, z) || free_neighbour(x + 1, y, z) ||
                 free_neighbour(x, y - 1, z) || free_neighbour(x, y + 1, z) ||
                 free_neighbour(x, y, z - 1) || free_neighbour(x, y, z + 1);
      if (any_free && self_code == CODE_UNKNOWN) begin
        v.kind = KIND_FRONTIER;
      end else if (any_free && self_code == CODE_OCCUPIED) begin
        v.kind = KIND_BOUNDARY;
      end
    end
    return v;
  endfunction

  // Applies one accepted transfer to the mirror. Writes outside the grid are dropped.
  function automatic void absorb_request(voxel_req_t r);
    if (r.func == FUNC_WRITE) begin
      if (within_grid(r.x, r.y, r.z)) occupancy_mirror[mirror_addr(r.x, r.y, r.z)] = r.code;
    end else begin
      expected_verdicts.push_back(classify_voxel(r.x, r.y, r.z));
      verdicts_owed++;
    end
  endfunction

  // Free cells are the most common so that frontiers and boundaries turn up often.
  function automatic code_t random_code();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return CODE_FREE;
    if (pick < 60) return CODE_OCCUPIED;
    if (pick < 90) return CODE_UNKNOWN;
    return CODE_RESERVED;
  endfunction

  function automatic void plan_write(int x, int y, int z, code_t code, bit hold);
    voxel_req_t r;
    r.func = FUNC_WRITE;
    r.x = 6'(x);
    r.y = 6'(y);
    r.z = 6'(z);
    r.code = code;
    r.hold_for_drain = hold;
    if (within_grid(x, y, z)) seeded[mirror_addr(x, y, z)] = 1'b1;
    pending_reqs.push_back(r);
    planned_items++;
  endfunction

  function automatic void seed_if_needed(int x, int y, int z);
    if (within_grid(x, y, z) && !seeded[mirror_addr(x, y, z)]) begin
      plan_write(x, y, z, random_code(), 1'b0);
    end
  endfunction

  // A classify reads the voxel itself and every neighbour inside the grid, so any of
  // those that has not been written yet gets a write with a random code first.
  function automatic void plan_classify(int x, int y, int z, bit hold);
    voxel_req_t r;
    seed_if_needed(x, y, z);
    seed_if_needed(x - 1, y, z);
    seed_if_needed(x + 1, y, z);
    seed_if_needed(x, y - 1, z);
    seed_if_needed(x, y + 1, z);
    seed_if_needed(x, y, z - 1);
    seed_if_needed(x, y, z + 1);
    r.func = FUNC_CLASSIFY;
    r.x = 6'(x);
    r.y = 6'(y);
    r.z = 6'(z);
    r.code = random_code();
    r.hold_for_drain = hold;
    pending_reqs.push_back(r);
    planned_items++;
  endfunction

  // A box corner at the low edge, at the high edge, or anywhere in between.
  function automatic int pick_origin(dim_t raw);
    int top;
    top = (clamp_dim(raw) > 4) ? clamp_dim(raw) - 4 : 0;
    case ($urandom_range(0, 2))
      0: begin
        return 0;
      end
      1: begin
        return top;
      end
      default: begin
        return $urandom_range(0, top);
      end
    endcase
  endfunction

  function automatic int box_coord(int origin);
    int c;
    c = origin + $urandom_range(0, 3);
    return (c > GRID_MAX - 1) ? GRID_MAX - 1 : c;
  endfunction

  // Waits until no request is queued or in flight and every verdict has been returned,
  // then leaves time for a write that is still being absorbed. Sampling at the falling
  // edge keeps the check clear of the driver's updates at the rising edge.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || verdicts_seen < verdicts_owed) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, dim_t value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_GRID_LENGTH: begin
        grid_len_q = value;
      end
      REG_GRID_WIDTH: begin
        grid_wid_q = value;
      end
      default: begin
        grid_hgt_q = value;
      end
    endcase
  endtask

  // One phase: a new grid shape, new idling rates and a burst of clustered traffic.
  task automatic run_phase(dim_t len, dim_t wid, dim_t hgt, int s_pct, int r_pct);
    int target;
    int ox;
    int oy;
    int oz;
    int pick;
    wait_idle();
    write_register(REG_GRID_LENGTH, len);
    write_register(REG_GRID_WIDTH, wid);
    write_register(REG_GRID_HEIGHT, hgt);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    @(negedge clk);
    // The far corner is out of range on any grid smaller than the largest, so each
    // phase opens with a write there (dropped on small grids) and a classify of it.
    plan_write(GRID_MAX - 1, GRID_MAX - 1, GRID_MAX - 1, CODE_UNKNOWN, 1'b0);
    plan_classify(GRID_MAX - 1, GRID_MAX - 1, GRID_MAX - 1, 1'b0);
    target = planned_items + ITEMS_PER_PHASE;
    ox = 0;
    oy = 0;
    oz = 0;
    while (planned_items < target) begin
      if (planned_items % REBOX_PERIOD == 0 || ox + oy + oz == 0) begin
        ox = pick_origin(grid_len_q);
        oy = pick_origin(grid_wid_q);
        oz = pick_origin(grid_hgt_q);
      end
      // Mostly writes and classifies packed into a small box, so that neighbours are
      // shared and every kind of verdict appears; the rest goes anywhere in the index space.
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        plan_write(box_coord(ox), box_coord(oy), box_coord(oz), random_code(),
                   $urandom_range(0, 99) < 3);
      end else if (pick < 88) begin
        plan_classify(box_coord(ox), box_coord(oy), box_coord(oz), $urandom_range(0, 99) < 3);
      end else if (pick < 94) begin
        plan_write($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                   random_code(), 1'b0);
      end else begin
        plan_classify($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                      1'b0);
      end
    end
  endtask

  // Driver. A new request is offered only when no transfer is held up by a stall, so the
  // payload of a stalled transfer never changes. A request marked to wait for a drain is
  // held back until every verdict issued so far has been returned.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_request(cur_req);
      if (!(in_valid && in_stall)) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(pending_reqs[0].hold_for_drain && verdicts_seen < verdicts_owed)) begin
          cur_req = pending_reqs.pop_front();
          in_func <= cur_req.func;
          in_x_index <= cur_req.x;
          in_y_index <= cur_req.y;
          in_z_index <= cur_req.z;
          in_cell_code <= cur_req.code;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result transfer is matched against the oldest outstanding verdict.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with none expected: kind %0d index %0d in_range %0b",
                   $time, out_kind, out_voxel_index, out_in_range);
          faults++;
        end else begin
          oldest = expected_verdicts.pop_front();
          if (out_kind !== oldest.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, oldest.kind, out_kind);
            faults++;
          end
          if (out_voxel_index !== oldest.index) begin
            $display("%0t: voxel_index expected %0d actual %0d",
                     $time, oldest.index, out_voxel_index);
            faults++;
          end
          if (out_in_range !== oldest.in_range) begin
            $display("%0t: in_range expected %0b actual %0b",
                     $time, oldest.in_range, out_in_range);
            faults++;
          end
        end
        verdicts_seen <= verdicts_seen + 1;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Directed opening on the reset grid, with the sender rarely idle and the receiver
    // mostly stalled.
    send_idle_pct = 8;
    recv_idle_pct = 84;
    @(negedge clk);
    // Corner voxel with one free neighbour: a frontier, then an obstacle boundary,
    // then the fourth code, which is neither.
    plan_write(0, 0, 0, CODE_UNKNOWN, 1'b0);
    plan_write(1, 0, 0, CODE_FREE, 1'b0);
    plan_write(0, 1, 0, CODE_OCCUPIED, 1'b0);
    plan_write(0, 0, 1, CODE_RESERVED, 1'b0);
    plan_classify(0, 0, 0, 1'b0);
    plan_write(0, 0, 0, CODE_OCCUPIED, 1'b0);
    plan_classify(0, 0, 0, 1'b0);
    plan_write(0, 0, 0, CODE_RESERVED, 1'b0);
    // This classify waits until the block has returned every earlier verdict.
    plan_classify(0, 0, 0, 1'b1);
    // No free neighbour left: an unknown voxel is then neither.
    plan_write(1, 0, 0, CODE_OCCUPIED, 1'b0);
    plan_write(0, 0, 0, CODE_UNKNOWN, 1'b0);
    plan_classify(0, 0, 0, 1'b0);
    // The far corners of the largest grid, where neighbours fall off the edge.
    plan_write(63, 63, 63, CODE_FREE, 1'b0);
    plan_write(62, 63, 63, CODE_UNKNOWN, 1'b0);
    plan_classify(62, 63, 63, 1'b0);
    plan_classify(63, 63, 63, 1'b0);
    plan_write(63, 0, 63, CODE_OCCUPIED, 1'b0);
    plan_classify(63, 0, 63, 1'b0);

    run_phase(7'd1, 7'd1, 7'd1, 8, 84);
    run_phase(7'd5, 7'd3, 7'd7, 8, 84);
    run_phase(7'd0, 7'd64, 7'd9, 84, 8);
    run_phase(7'd127, 7'd100, 7'd65, 84, 8);
    run_phase(7'd64, 7'd2, 7'd1, 84, 8);
    run_phase(dim_t'($urandom_range(1, 12)), dim_t'($urandom_range(1, 12)),
              dim_t'($urandom_range(1, 12)), 0, 0);
    run_phase(7'd64, 7'd64, 7'd64, 0, 0);

    wait_idle();
    if (faults == 0 && expected_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
